@@ rtl/ucrb_pkg.sv @@
// ----------------------------------------------------------------------------
// ucrb_pkg
// Shared types and constants for the UART ring buffer block: item operation
// codes, field widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
package ucrb_pkg;

  // Default queue depths
  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int ERR_W      = 3;
  localparam int LEVEL_W    = 5;
  // Widest buffer address (depths up to 256)
  localparam int ADDR_MAX_W = 8;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_PUT_TX   = 2'd0,
    OP_TX_READY = 2'd1,
    OP_RX_BYTE  = 2'd2,
    OP_GET_RX   = 2'd3
  } op_t;

  // Status part of one result beat
  typedef struct packed {
    logic               data_valid;
    logic               accepted;
    logic               tx_request;
    logic               tx_overflow;
    logic               rx_overflow;
    logic [ERR_W-1:0]   error_flags;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } res_t;

  // Buffer access plus finished status, one per accepted beat
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic                  sel_rx;
    logic [ADDR_MAX_W-1:0] addr;
    logic [BYTE_W-1:0]     wdata;
    res_t                  res;
  } cmd_t;

endpackage

@@ rtl/ucrb_ram.sv @@
// ----------------------------------------------------------------------------
// ucrb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module ucrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ucrb_front.sv @@
// ----------------------------------------------------------------------------
// ucrb_front
// Accepts item beats, decides push, pop, drop or flag for each, keeps the
// queue pointers, fill counts and sticky flags, and emits a command record.
// ----------------------------------------------------------------------------
module ucrb_front #(
  parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [ucrb_pkg::BYTE_W-1:0] data_in,
  input  logic [ucrb_pkg::ERR_W-1:0]  rx_errors,
  input  logic                        q_full,
  output logic                        q_push,
  output ucrb_pkg::cmd_t              q_cmd
);

  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RAW = $clog2(RX_DEPTH);
  localparam int TFW = $clog2(TX_DEPTH + 1);
  localparam int RFW = $clog2(RX_DEPTH + 1);
  localparam int LW  = ucrb_pkg::LEVEL_W;
  localparam int AMW = ucrb_pkg::ADDR_MAX_W;
  localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);
  localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
  localparam logic [TFW-1:0] TX_FULL = TFW'(TX_DEPTH);
  localparam logic [RFW-1:0] RX_FULL = RFW'(RX_DEPTH);

  logic [TAW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [RAW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [TFW-1:0] tx_fill, tx_fill_next;
  logic [RFW-1:0] rx_fill, rx_fill_next;
  logic tx_ovf, tx_ovf_next, rx_ovf, rx_ovf_next, req, req_next;
  logic [ucrb_pkg::ERR_W-1:0] err, err_next;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Classify the beat and work out the next state
  always_comb begin
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_fill_next = tx_fill;
    rx_fill_next = rx_fill;
    tx_ovf_next  = tx_ovf;
    rx_ovf_next  = rx_ovf;
    err_next     = err;
    req_next     = req;
    q_cmd        = '0;
    q_cmd.wdata  = data_in;
    case (ucrb_pkg::op_t'(op))
      ucrb_pkg::OP_PUT_TX: begin
        if (tx_fill != TX_FULL) begin
          q_cmd.wr_en    = 1'b1;
          q_cmd.addr     = AMW'(tx_head);
          q_cmd.res.accepted = 1'b1;
          tx_head_next   = (tx_head == TX_LAST) ? '0 : tx_head + TAW'(1);
          tx_fill_next   = tx_fill + TFW'(1);
          req_next       = 1'b1;
        end else begin
          tx_ovf_next = 1'b1;
        end
      end
      ucrb_pkg::OP_TX_READY: begin
        if (tx_fill != '0) begin
          q_cmd.rd_en    = 1'b1;
          q_cmd.addr     = AMW'(tx_tail);
          q_cmd.res.data_valid = 1'b1;
          tx_tail_next   = (tx_tail == TX_LAST) ? '0 : tx_tail + TAW'(1);
          tx_fill_next   = tx_fill - TFW'(1);
          tx_ovf_next    = 1'b0;
        end else begin
          req_next = 1'b0;
        end
      end
      ucrb_pkg::OP_RX_BYTE: begin
        err_next     = err | rx_errors;
        q_cmd.sel_rx = 1'b1;
        if (rx_fill != RX_FULL) begin
          q_cmd.wr_en    = 1'b1;
          q_cmd.addr     = AMW'(rx_head);
          q_cmd.res.accepted = 1'b1;
          rx_head_next   = (rx_head == RX_LAST) ? '0 : rx_head + RAW'(1);
          rx_fill_next   = rx_fill + RFW'(1);
        end else begin
          rx_ovf_next = 1'b1;
        end
      end
      ucrb_pkg::OP_GET_RX: begin
        q_cmd.sel_rx = 1'b1;
        if (rx_fill != '0) begin
          q_cmd.rd_en    = 1'b1;
          q_cmd.addr     = AMW'(rx_tail);
          q_cmd.res.data_valid = 1'b1;
          rx_tail_next   = (rx_tail == RX_LAST) ? '0 : rx_tail + RAW'(1);
          rx_fill_next   = rx_fill - RFW'(1);
          rx_ovf_next    = 1'b0;
        end
      end
      default: begin
        q_cmd.wr_en = 1'b0;
      end
    endcase
    q_cmd.res.tx_request  = req_next;
    q_cmd.res.tx_overflow = tx_ovf_next;
    q_cmd.res.rx_overflow = rx_ovf_next;
    q_cmd.res.error_flags = err_next;
    q_cmd.res.tx_level    = LW'(tx_fill_next);
    q_cmd.res.rx_level    = LW'(rx_fill_next);
  end

  // Advance state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      tx_fill <= '0;
      rx_fill <= '0;
      tx_ovf  <= 1'b0;
      rx_ovf  <= 1'b0;
      err     <= '0;
      req     <= 1'b0;
    end else if (accept) begin
      tx_head <= tx_head_next;
      tx_tail <= tx_tail_next;
      rx_head <= rx_head_next;
      rx_tail <= rx_tail_next;
      tx_fill <= tx_fill_next;
      rx_fill <= rx_fill_next;
      tx_ovf  <= tx_ovf_next;
      rx_ovf  <= rx_ovf_next;
      err     <= err_next;
      req     <= req_next;
    end
  end

`ifndef SYNTH
  // A put on a full transmit queue leaves the fill alone and flags overflow
  a_tx_full_put: assert property (@(posedge clk) disable iff (rst)
    (accept && op == ucrb_pkg::OP_PUT_TX && tx_fill == TX_FULL)
      |=> (tx_ovf && $stable(tx_fill)))
    else $error("transmit put on full queue changed the fill");

  // A transmit pop drops the fill by one and clears overflow
  a_tx_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && op == ucrb_pkg::OP_TX_READY && tx_fill != '0)
      |=> (!tx_ovf && tx_fill == $past(tx_fill) - TFW'(1)))
    else $error("transmit pop did not update fill and overflow");
`endif

endmodule

@@ rtl/ucrb_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// ucrb_cmd_queue
// Two-entry command queue between the front and the back, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module ucrb_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ucrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ucrb_pkg::cmd_t head_cmd
);

  ucrb_pkg::cmd_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTH
  // Never push into a full queue nor pop an empty one
  a_q_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("command queue overrun or underrun");
`endif

endmodule

@@ rtl/ucrb_back.sv @@
// ----------------------------------------------------------------------------
// ucrb_back
// Carries out buffer writes and reads for queued commands and holds the
// result beat in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ucrb_back #(
  parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ucrb_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ucrb_pkg::BYTE_W-1:0] data_out,
  output ucrb_pkg::res_t              res
);

  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RAW = $clog2(RX_DEPTH);
  localparam int BW  = ucrb_pkg::BYTE_W;

  logic          issue;
  logic          tx_we, tx_re, rx_we, rx_re;
  logic          sel_rx;
  logic [BW-1:0] tx_rdata, rx_rdata;

  // Issue when the output slot is free or being taken
  assign issue = q_valid && (!out_valid || !out_stall);
  assign q_pop = issue;

  assign tx_we = issue && q_cmd.wr_en && !q_cmd.sel_rx;
  assign tx_re = issue && q_cmd.rd_en && !q_cmd.sel_rx;
  assign rx_we = issue && q_cmd.wr_en && q_cmd.sel_rx;
  assign rx_re = issue && q_cmd.rd_en && q_cmd.sel_rx;

  ucrb_ram #(
    .WIDTH (BW),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (q_cmd.addr[TAW-1:0]),
    .wdata (q_cmd.wdata),
    .re    (tx_re),
    .raddr (q_cmd.addr[TAW-1:0]),
    .rdata (tx_rdata)
  );

  ucrb_ram #(
    .WIDTH (BW),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (q_cmd.addr[RAW-1:0]),
    .wdata (q_cmd.wdata),
    .re    (rx_re),
    .raddr (q_cmd.addr[RAW-1:0]),
    .rdata (rx_rdata)
  );

  // Output register: load on issue, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res    <= q_cmd.res;
      sel_rx <= q_cmd.sel_rx;
    end
  end

  // Read data arrives with the beat; zero when nothing was popped
  always_comb begin
    if (!res.data_valid) begin
      data_out = '0;
    end else if (sel_rx) begin
      data_out = rx_rdata;
    end else begin
      data_out = tx_rdata;
    end
  end

`ifndef SYNTH
  // At most one buffer access per cycle
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tx_we, tx_re, rx_we, rx_re}))
    else $error("more than one buffer access in a cycle");
`endif

endmodule

@@ rtl/uart_tx_rx_ring_buffers_core.sv @@
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_core
// Transmit and receive byte ring buffers for a UART.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat: op
//   selects host put to the transmit queue, transmitter ready (pop transmit),
//   byte received (push receive with its error bits) or host get (pop
//   receive). Every input beat yields exactly one result beat on the output
//   channel (out_valid / out_stall) with the popped byte, the accepted flag,
//   the transmit request, the sticky overflow and error flags and both fill
//   levels as they stand after that operation.
//   Path: the accepting edge writes the command queue, and the edge that
//   issues the command from its head loads the result register behind
//   out_valid and does the buffer RAM access whose registered read feeds
//   data_out. Throughput is one beat per cycle while the receiver does not
//   stall, set by the single RAM access the back issues per cycle. A get on
//   an empty receive queue reports data_valid 0.
//   Reset clears pointers, levels, flags and the transmit request; buffer
//   contents are not cleared and need no clearing pass.
//   When the receiver stalls, the result is held, the two-entry command
//   queue fills and then in_stall rises until results drain.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_core #(
  parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [ucrb_pkg::BYTE_W-1:0]  data_in,
  input  logic [ucrb_pkg::ERR_W-1:0]   rx_errors,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ucrb_pkg::BYTE_W-1:0]  data_out,
  output logic                         data_valid,
  output logic                         accepted,
  output logic                         tx_request,
  output logic                         tx_overflow,
  output logic                         rx_overflow,
  output logic [ucrb_pkg::ERR_W-1:0]   error_flags,
  output logic [ucrb_pkg::LEVEL_W-1:0] tx_level,
  output logic [ucrb_pkg::LEVEL_W-1:0] rx_level
);

  logic           q_full, q_push, q_pop, q_valid;
  ucrb_pkg::cmd_t push_cmd, head_cmd;
  ucrb_pkg::res_t res;

  ucrb_front #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_in   (data_in),
    .rx_errors (rx_errors),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  ucrb_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  ucrb_back #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .res       (res)
  );

  // Spread the result status onto its ports
  assign data_valid  = res.data_valid;
  assign accepted    = res.accepted;
  assign tx_request  = res.tx_request;
  assign tx_overflow = res.tx_overflow;
  assign rx_overflow = res.rx_overflow;
  assign error_flags = res.error_flags;
  assign tx_level    = res.tx_level;
  assign rx_level    = res.rx_level;

endmodule
